FILE: hdl/rfs_pkg.sv
// Shared constants, types and helpers of the raster frame statistics block.
`default_nettype none

package rfs_pkg;

  // Frame size bounds
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 256;

  // Derived widths
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int RUN_W = $clog2(MAX_HEIGHT + 1);

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int THR_W      = 8;
  localparam int ASYM_W     = 9;
  localparam int CNT_W      = 18;
  localparam int LONG_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_WID_W  = 10;
  localparam int CFG_HGT_W  = 9;

  // Register reset values
  localparam int WIDTH_RESET     = 320;
  localparam int HEIGHT_RESET    = 200;
  localparam int THRESHOLD_RESET = 128;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST_THRESHOLD = 2'd2;

  // One line store entry: pixel, final contrast mark and vertical run
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             mark;
    logic [RUN_W-1:0] run;
  } line_entry_t;

  // Position and flags of the pixel in the compute stage
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    logic             col_nz;
    logic             row_nz;
    logic             first;
    logic             last_col;
    logic             frame_end;
    logic             mirror_en;
    logic             mirror_left;
  } pixel_ctx_t;

  // One result item
  typedef struct packed {
    logic [PIX_W-1:0]  max_level;
    logic [PIX_W-1:0]  min_level;
    logic [ASYM_W-1:0] asymmetric_rows;
    logic [CNT_W-1:0]  contrast_pixels;
    logic [LONG_W-1:0] longest_run;
    logic              frame_done;
  } result_t;

  // True when two levels differ by more than the threshold
  function automatic logic contrasts(input logic [PIX_W-1:0] a,
                                     input logic [PIX_W-1:0] b,
                                     input logic [THR_W-1:0] thr);
    logic [PIX_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > thr;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rfs_line_store.sv
// Line store memory with one write port, two read ports and write forwarding.
`default_nettype none

module rfs_line_store (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [rfs_pkg::COL_W-1:0] rd_addr,
  input  wire logic [rfs_pkg::COL_W-1:0] mir_addr,
  input  wire logic                      wr_en,
  input  wire logic [rfs_pkg::COL_W-1:0] wr_addr,
  input  wire rfs_pkg::line_entry_t      wr_data,
  output rfs_pkg::line_entry_t           rd_data,
  output logic [rfs_pkg::PIX_W-1:0]      mir_pixel
);

  rfs_pkg::line_entry_t             mem [rfs_pkg::MAX_WIDTH];
  rfs_pkg::line_entry_t             rd_q;
  logic [rfs_pkg::PIX_W-1:0]        mir_q;
  rfs_pkg::line_entry_t             fwd_data;
  logic                             rd_hit;
  logic                             mir_hit;

  // Write the entry and read both ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      mir_q    <= mem[mir_addr].pixel;
      fwd_data <= wr_data;
    end
  end

  // Note a write that lands on an address being read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_hit  <= 1'b0;
      mir_hit <= 1'b0;
    end else if (rd_en) begin
      rd_hit  <= wr_en && (wr_addr == rd_addr);
      mir_hit <= wr_en && (wr_addr == mir_addr);
    end
  end

  // Forward the fresh entry over the stale memory word
  assign rd_data   = rd_hit ? fwd_data : rd_q;
  assign mir_pixel = mir_hit ? fwd_data.pixel : mir_q;

  a_fwd_upper: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en && (wr_addr == rd_addr)) |=> (rd_data == $past(wr_data)))
    else $error("line store: upper read missed a same-cycle write");

  a_fwd_mirror: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en && (wr_addr == mir_addr)) |=> (mir_pixel == $past(wr_data.pixel)))
    else $error("line store: mirror read missed a same-cycle write");

  a_hold_read: assert property (@(posedge clk) disable iff (rst)
    !rd_en |=> ($stable(rd_data) && $stable(mir_pixel)))
    else $error("line store: read data changed without a read");

endmodule

`default_nettype wire

FILE: hdl/rfs_scan.sv
// Configuration registers, raster position counters and the compute stage register.
`default_nettype none

module rfs_scan (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rfs_pkg::PIX_W-1:0]     pixel,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rfs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          advance,
  output logic                               rd_en,
  output logic [rfs_pkg::COL_W-1:0]          rd_addr,
  output logic [rfs_pkg::COL_W-1:0]          mir_addr,
  output logic                               ctx_valid,
  output rfs_pkg::pixel_ctx_t                ctx,
  output logic [rfs_pkg::THR_W-1:0]          threshold
);

  logic [rfs_pkg::WID_W-1:0]     width;
  logic [rfs_pkg::HGT_W-1:0]     height;
  logic [rfs_pkg::COL_W-1:0]     col;
  logic [rfs_pkg::ROW_W-1:0]     row;
  logic                          accept;
  logic                          cfg_fire;
  logic                          last_col;
  logic                          last_row;
  logic [rfs_pkg::WID_W:0]       col_twice;
  logic [rfs_pkg::WID_W-1:0]     mirror_full;
  logic [rfs_pkg::CFG_WID_W-1:0] wid_in;
  logic [rfs_pkg::CFG_HGT_W-1:0] hgt_in;
  logic [rfs_pkg::WID_W-1:0]     width_next;
  logic [rfs_pkg::HGT_W-1:0]     height_next;
  rfs_pkg::pixel_ctx_t           ctx_next;

  // Transfer handshakes
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = ctx_valid && !advance;
  assign accept    = in_valid && !in_stall;

  // Saturate size writes into the legal range
  assign wid_in      = cfg_data[rfs_pkg::CFG_WID_W-1:0];
  assign hgt_in      = cfg_data[rfs_pkg::CFG_HGT_W-1:0];
  assign width_next  = (wid_in < rfs_pkg::CFG_WID_W'(2)) ? rfs_pkg::WID_W'(2) :
                       (32'(wid_in) > 32'(rfs_pkg::MAX_WIDTH)) ?
                       rfs_pkg::WID_W'(rfs_pkg::MAX_WIDTH) : rfs_pkg::WID_W'(wid_in);
  assign height_next = (hgt_in < rfs_pkg::CFG_HGT_W'(1)) ? rfs_pkg::HGT_W'(1) :
                       (32'(hgt_in) > 32'(rfs_pkg::MAX_HEIGHT)) ?
                       rfs_pkg::HGT_W'(rfs_pkg::MAX_HEIGHT) : rfs_pkg::HGT_W'(hgt_in);

  // Position flags and the mirror address of the incoming pixel
  assign last_col    = (rfs_pkg::WID_W'(col) == (width - rfs_pkg::WID_W'(1)));
  assign last_row    = (rfs_pkg::HGT_W'(row) == (height - rfs_pkg::HGT_W'(1)));
  assign col_twice   = (rfs_pkg::WID_W + 1)'({col, 1'b0});
  assign mirror_full = width - rfs_pkg::WID_W'(1) - rfs_pkg::WID_W'(col);

  always_comb begin
    ctx_next             = '0;
    ctx_next.pixel       = pixel;
    ctx_next.col         = col;
    ctx_next.col_nz      = (col != '0);
    ctx_next.row_nz      = (row != '0);
    ctx_next.first       = (col == '0) && (row == '0);
    ctx_next.last_col    = last_col;
    ctx_next.frame_end   = last_col && last_row;
    ctx_next.mirror_en   = (col_twice >= (rfs_pkg::WID_W + 1)'(width));
    ctx_next.mirror_left = (col_twice == (rfs_pkg::WID_W + 1)'(width));
  end

  // Read the line store for the accepted pixel
  assign rd_en    = accept;
  assign rd_addr  = col;
  assign mir_addr = mirror_full[rfs_pkg::COL_W-1:0];

  // Take register writes; advance the raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      width     <= rfs_pkg::WID_W'(rfs_pkg::WIDTH_RESET);
      height    <= rfs_pkg::HGT_W'(rfs_pkg::HEIGHT_RESET);
      threshold <= rfs_pkg::THR_W'(rfs_pkg::THRESHOLD_RESET);
      col       <= '0;
      row       <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        rfs_pkg::CFG_IMAGE_WIDTH: begin
          width <= width_next;
          col   <= '0;
          row   <= '0;
        end
        rfs_pkg::CFG_IMAGE_HEIGHT: begin
          height <= height_next;
          col    <= '0;
          row    <= '0;
        end
        rfs_pkg::CFG_CONTRAST_THRESHOLD: begin
          threshold <= cfg_data[rfs_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : (row + rfs_pkg::ROW_W'(1));
      end else begin
        col <= col + rfs_pkg::COL_W'(1);
      end
    end
  end

  // Hold the pixel in the compute stage until it moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_valid <= 1'b0;
    end else if (accept) begin
      ctx_valid <= 1'b1;
    end else if (advance) begin
      ctx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctx <= ctx_next;
    end
  end

  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    ctx_valid |-> (rfs_pkg::WID_W'(ctx.col) < width))
    else $error("scan: column beyond the frame width");

  a_size_restart: assert property (@(posedge clk) disable iff (rst)
    (cfg_fire && ((cfg_index == rfs_pkg::CFG_IMAGE_WIDTH) ||
                  (cfg_index == rfs_pkg::CFG_IMAGE_HEIGHT)))
    |=> ((col == '0) && (row == '0)))
    else $error("scan: size write did not restart the frame");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (ctx_valid && !advance) |=> (ctx_valid && $stable(ctx)))
    else $error("scan: stalled compute stage lost its pixel");

endmodule

`default_nettype wire

FILE: hdl/rfs_stats.sv
// Compute stage: contrast, run and symmetry checks, running statistics, output register.
`default_nettype none

module rfs_stats (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      ctx_valid,
  input  wire rfs_pkg::pixel_ctx_t       ctx,
  input  wire logic [rfs_pkg::THR_W-1:0] threshold,
  input  wire rfs_pkg::line_entry_t      upper_entry,
  input  wire logic [rfs_pkg::PIX_W-1:0] mir_pixel,
  output logic                           advance,
  output logic                           wr_en,
  output logic [rfs_pkg::COL_W-1:0]      wr_addr,
  output rfs_pkg::line_entry_t           wr_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output rfs_pkg::result_t               result
);

  logic                          fire;

  // Running statistics
  logic [rfs_pkg::PIX_W-1:0]     max_seen;
  logic [rfs_pkg::PIX_W-1:0]     min_seen;
  logic [rfs_pkg::ASYM_W-1:0]    asym_count;
  logic                          row_mismatch;
  logic [rfs_pkg::CNT_W-1:0]     contrast_count;
  logic [rfs_pkg::RUN_W-1:0]     best_run;

  // Left neighbour and last column of the previous row
  logic [rfs_pkg::PIX_W-1:0]     left_pixel;
  logic                          left_marked;
  logic [rfs_pkg::RUN_W-1:0]     left_run;
  rfs_pkg::line_entry_t          tail;

  logic [rfs_pkg::PIX_W-1:0]     max_next;
  logic [rfs_pkg::PIX_W-1:0]     min_next;
  logic [rfs_pkg::ASYM_W-1:0]    asym_next;
  logic                          mismatch_next;
  logic [rfs_pkg::CNT_W-1:0]     count_next;
  logic [rfs_pkg::RUN_W-1:0]     best_next;
  logic [rfs_pkg::RUN_W-1:0]     run_next;
  logic                          cur_marked;
  logic                          left_marked_upd;
  rfs_pkg::result_t              result_next;

  assign advance = !out_valid || !out_stall;
  assign fire    = ctx_valid && advance;

  // Work out the statistics after this pixel
  always_comb begin
    rfs_pkg::line_entry_t      upper;
    logic [rfs_pkg::PIX_W-1:0] max_base;
    logic [rfs_pkg::PIX_W-1:0] min_base;
    logic [rfs_pkg::ASYM_W-1:0] asym_base;
    logic [rfs_pkg::CNT_W-1:0] count_base;
    logic [rfs_pkg::RUN_W-1:0] best_base;
    logic                      mismatch_base;
    logic                      marked_base;
    logic                      left_hit;
    logic                      up_hit;
    logic                      row_diff;
    logic [rfs_pkg::PIX_W-1:0] mirror_px;

    // Restart everything on the first pixel of a frame
    max_base      = ctx.first ? '0 : max_seen;
    min_base      = ctx.first ? '1 : min_seen;
    asym_base     = ctx.first ? '0 : asym_count;
    count_base    = ctx.first ? '0 : contrast_count;
    best_base     = ctx.first ? '0 : best_run;
    mismatch_base = ctx.first ? 1'b0 : row_mismatch;
    marked_base   = ctx.first ? 1'b0 : left_marked;

    // The last column of the row above sits in the tail register
    upper = ctx.last_col ? tail : upper_entry;

    max_next = (ctx.pixel > max_base) ? ctx.pixel : max_base;
    min_next = (ctx.pixel < min_base) ? ctx.pixel : min_base;

    // Contrast against left and upper neighbours
    left_hit = ctx.col_nz && rfs_pkg::contrasts(ctx.pixel, left_pixel, threshold);
    up_hit   = ctx.row_nz && rfs_pkg::contrasts(ctx.pixel, upper.pixel, threshold);
    cur_marked      = left_hit || up_hit;
    left_marked_upd = marked_base || left_hit;
    count_next = count_base
               + rfs_pkg::CNT_W'(left_hit && !marked_base)
               + rfs_pkg::CNT_W'(up_hit && !upper.mark)
               + rfs_pkg::CNT_W'(cur_marked);

    // Extend or restart the vertical run of this column
    run_next  = (ctx.row_nz && (upper.pixel == ctx.pixel)) ?
                (upper.run + rfs_pkg::RUN_W'(1)) : rfs_pkg::RUN_W'(1);
    best_next = (run_next > best_base) ? run_next : best_base;

    // Compare against the mirror pixel of this row
    mirror_px     = ctx.mirror_left ? left_pixel : mir_pixel;
    row_diff      = ctx.mirror_en && (mirror_px != ctx.pixel);
    mismatch_next = mismatch_base || row_diff;
    asym_next     = asym_base + rfs_pkg::ASYM_W'(ctx.last_col && mismatch_next);

    result_next                 = '0;
    result_next.max_level       = max_next;
    result_next.min_level       = min_next;
    result_next.asymmetric_rows = asym_next;
    result_next.contrast_pixels = count_next;
    result_next.longest_run     = rfs_pkg::LONG_W'(best_next);
    result_next.frame_done      = ctx.frame_end;
  end

  // Write back the left neighbour now that its mark is final
  assign wr_en         = fire && ctx.col_nz;
  assign wr_addr       = ctx.col - rfs_pkg::COL_W'(1);
  assign wr_data.pixel = left_pixel;
  assign wr_data.mark  = left_marked_upd;
  assign wr_data.run   = left_run;

  // Update running statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      max_seen       <= '0;
      min_seen       <= '1;
      asym_count     <= '0;
      row_mismatch   <= 1'b0;
      contrast_count <= '0;
      best_run       <= '0;
      left_marked    <= 1'b0;
    end else if (fire) begin
      max_seen       <= max_next;
      min_seen       <= min_next;
      asym_count     <= asym_next;
      row_mismatch   <= ctx.last_col ? 1'b0 : mismatch_next;
      contrast_count <= count_next;
      best_run       <= best_next;
      left_marked    <= cur_marked;
    end
  end

  // Shift the current pixel into the left slot; park the last column
  always_ff @(posedge clk) begin
    if (fire) begin
      left_pixel <= ctx.pixel;
      left_run   <= run_next;
      if (ctx.last_col) begin
        tail.pixel <= ctx.pixel;
        tail.mark  <= cur_marked;
        tail.run   <= run_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.min_level <= result.max_level))
    else $error("stats: darkest level above brightest level");

  a_row_close: assert property (@(posedge clk) disable iff (rst)
    (fire && ctx.last_col) |=> !row_mismatch)
    else $error("stats: row mismatch not cleared at row end");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (fire && ctx.first) |=> ((contrast_count == '0) && (asym_count == '0) &&
                              (best_run == rfs_pkg::RUN_W'(1))))
    else $error("stats: frame start did not restart the statistics");

endmodule

`default_nettype wire

FILE: hdl/raster_frame_statistics.sv
// Top level of the raster frame statistics block.
`default_nettype none

// Takes one 8-bit grey pixel per clock in raster order while in_stall is low
// and returns, for every pixel, the running statistics of the frame: brightest
// and darkest level, completed rows that are not mirror symmetric, pixels that
// contrast with a 4-neighbour by more than contrast_threshold, the longest
// vertical run of equal pixels in a column, and a flag on the frame's last
// pixel. A pixel can be taken every cycle unless in_stall is high; it is held
// in the compute stage register and its result is then loaded into the output
// register, and a stalled output holds at most two pixels (compute stage and
// output register) before in_stall rises. The rate is set by the line store, a
// single memory of MAX_WIDTH entries (pixel, final contrast mark, run length)
// read at the current and the mirror column and written back at the previous
// column, with same-cycle writes forwarded to the reads. Row zero of a frame
// ignores the upper entries that it reads from the store, so no clearing pass
// is needed after reset or at a frame start. cfg_ready is always high; a write
// to image_width or image_height makes the next pixel the first of a new
// frame. Register writes are meant for an idle block.
module raster_frame_statistics (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rfs_pkg::PIX_W-1:0]      pixel,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [rfs_pkg::PIX_W-1:0]           max_level,
  output logic [rfs_pkg::PIX_W-1:0]           min_level,
  output logic [rfs_pkg::ASYM_W-1:0]          asymmetric_rows,
  output logic [rfs_pkg::CNT_W-1:0]           contrast_pixels,
  output logic [rfs_pkg::LONG_W-1:0]          longest_run,
  output logic                                frame_done,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rfs_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                          advance;
  logic                          rd_en;
  logic [rfs_pkg::COL_W-1:0]     rd_addr;
  logic [rfs_pkg::COL_W-1:0]     mir_addr;
  logic                          ctx_valid;
  rfs_pkg::pixel_ctx_t           ctx;
  logic [rfs_pkg::THR_W-1:0]     threshold;
  logic                          wr_en;
  logic [rfs_pkg::COL_W-1:0]     wr_addr;
  rfs_pkg::line_entry_t          wr_data;
  rfs_pkg::line_entry_t          upper_entry;
  logic [rfs_pkg::PIX_W-1:0]     mir_pixel;
  rfs_pkg::result_t              result;

  // Position, registers and compute stage register
  rfs_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel     (pixel),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .mir_addr  (mir_addr),
    .ctx_valid (ctx_valid),
    .ctx       (ctx),
    .threshold (threshold)
  );

  // Previous row store
  rfs_line_store u_line_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .mir_addr  (mir_addr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data   (upper_entry),
    .mir_pixel (mir_pixel)
  );

  // Statistics and output register
  rfs_stats u_stats (
    .clk         (clk),
    .rst         (rst),
    .ctx_valid   (ctx_valid),
    .ctx         (ctx),
    .threshold   (threshold),
    .upper_entry (upper_entry),
    .mir_pixel   (mir_pixel),
    .advance     (advance),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result)
  );

  assign max_level       = result.max_level;
  assign min_level       = result.min_level;
  assign asymmetric_rows = result.asymmetric_rows;
  assign contrast_pixels = result.contrast_pixels;
  assign longest_run     = result.longest_run;
  assign frame_done      = result.frame_done;

endmodule

`default_nettype wire

FILE: tb/tb_raster_frame_statistics.sv
// Self-checking testbench for the raster frame statistics block.
`default_nettype none

module tb_raster_frame_statistics;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rfs_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 150;
  localparam int SETTLE_CYCLES = 4;

  typedef enum int {
    STYLE_NOISE, STYLE_TWO_LEVEL, STYLE_MIRROR, STYLE_COLUMN_RUN, STYLE_FLAT
  } pixel_style_t;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
  } stall_style_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [rfs_pkg::PIX_W-1:0]      pixel = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [rfs_pkg::PIX_W-1:0]      max_level;
  logic [rfs_pkg::PIX_W-1:0]      min_level;
  logic [rfs_pkg::ASYM_W-1:0]     asymmetric_rows;
  logic [rfs_pkg::CNT_W-1:0]      contrast_pixels;
  logic [rfs_pkg::LONG_W-1:0]     longest_run;
  logic                           frame_done;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  raster_frame_statistics uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .max_level(max_level), .min_level(min_level),
    .asymmetric_rows(asymmetric_rows), .contrast_pixels(contrast_pixels),
    .longest_run(longest_run), .frame_done(frame_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Frame statistics predictor: configuration, position and stores
  int                        cur_width = rfs_pkg::WIDTH_RESET;
  int                        cur_height = rfs_pkg::HEIGHT_RESET;
  int                        cur_threshold = rfs_pkg::THRESHOLD_RESET;
  int                        col_pos = 0;
  int                        row_pos = 0;
  int                        max_seen = 0;
  int                        min_seen = 255;
  int                        asym_count = 0;
  bit                        row_mismatch = 1'b0;
  int                        contrast_count = 0;
  logic [rfs_pkg::PIX_W-1:0] left_px = '0;
  bit                        left_mark = 1'b0;
  logic [rfs_pkg::PIX_W-1:0] line_px [rfs_pkg::MAX_WIDTH];
  bit                        line_mark [rfs_pkg::MAX_WIDTH];
  int                        col_run [rfs_pkg::MAX_WIDTH];
  int                        best_run = 0;

  rfs_pkg::result_t          expected_stats [$];
  rfs_pkg::result_t          want_stats;

  int                        error_count = 0;
  int                        pixels_sent = 0;
  int                        results_checked = 0;
  int                        frames_seen = 0;
  int                        config_writes = 0;

  // Sender pacing and pixel generation
  bit                        bursty = 1'b0;
  int                        burst_left = 0;
  pixel_style_t              style = STYLE_NOISE;
  logic [rfs_pkg::PIX_W-1:0] level_a = '0;
  logic [rfs_pkg::PIX_W-1:0] level_b = '1;

  // Receiver stall pattern
  stall_style_t              stall_style = STALL_NONE;
  int                        stall_cycle = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report_mismatch(name, got, want);
  endtask

  function automatic bit exceeds_threshold(input int a, input int b);
    int d;
    d = (a > b) ? a - b : b - a;
    return d > cur_threshold;
  endfunction

  // Clear the stores and restart the statistics at a frame start
  function automatic void restart_frame();
    for (int i = 0; i < rfs_pkg::MAX_WIDTH; i++) begin
      line_px[i] = '0;
      line_mark[i] = 1'b0;
      col_run[i] = 0;
    end
    max_seen = 0;
    min_seen = 255;
    asym_count = 0;
    row_mismatch = 1'b0;
    contrast_count = 0;
    left_px = '0;
    left_mark = 1'b0;
    best_run = 0;
  endfunction

  // Advance the predictor by one pixel and return the statistics it yields
  function automatic rfs_pkg::result_t predict_stats(input logic [rfs_pkg::PIX_W-1:0] px);
    int               col;
    int               row;
    int               m;
    bit               marked;
    rfs_pkg::result_t r;
    col = col_pos;
    row = row_pos;
    marked = 1'b0;
    r = '0;
    if (col >= cur_width) col = cur_width - 1;
    if (row >= cur_height) row = cur_height - 1;
    if (col == 0 && row == 0) restart_frame();

    if (int'(px) > max_seen) max_seen = int'(px);
    if (int'(px) < min_seen) min_seen = int'(px);

    // left neighbour: mark it once, then the current pixel
    if (col > 0 && exceeds_threshold(int'(px), int'(left_px))) begin
      if (!left_mark) begin
        left_mark = 1'b1;
        contrast_count++;
      end
      marked = 1'b1;
    end
    // upper neighbour
    if (row > 0 && exceeds_threshold(int'(px), int'(line_px[col]))) begin
      if (!line_mark[col]) contrast_count++;
      marked = 1'b1;
    end
    if (marked) contrast_count++;

    // vertical run in this column
    if (row > 0 && line_px[col] == px) col_run[col] = col_run[col] + 1;
    else col_run[col] = 1;
    if (col_run[col] > best_run) best_run = col_run[col];

    // right half against its mirror in the stored left half
    if (2 * col > cur_width - 1) begin
      m = cur_width - 1 - col;
      if (line_px[m] != px) row_mismatch = 1'b1;
    end

    if (col > 0) line_mark[col - 1] = left_mark;
    line_mark[col] = marked;
    line_px[col] = px;
    left_px = px;
    left_mark = marked;

    if (col == cur_width - 1) begin
      if (row_mismatch) asym_count++;
      row_mismatch = 1'b0;
      col_pos = 0;
      if (row == cur_height - 1) begin
        r.frame_done = 1'b1;
        row_pos = 0;
      end else begin
        row_pos = row + 1;
      end
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end

    r.max_level = rfs_pkg::PIX_W'(max_seen);
    r.min_level = rfs_pkg::PIX_W'(min_seen);
    r.asymmetric_rows = rfs_pkg::ASYM_W'(asym_count);
    r.contrast_pixels = rfs_pkg::CNT_W'(contrast_count);
    r.longest_run = rfs_pkg::LONG_W'(best_run);
    return r;
  endfunction

  // Choose the next pixel from the current style and the predictor's position
  function automatic logic [rfs_pkg::PIX_W-1:0] pick_pixel();
    logic [rfs_pkg::PIX_W-1:0] p;
    p = rfs_pkg::PIX_W'($urandom);
    case (style)
      STYLE_TWO_LEVEL: p = $urandom_range(0, 1) ? level_a : level_b;
      STYLE_MIRROR: begin
        if (2 * col_pos > cur_width - 1 && $urandom_range(0, 9) != 0)
          p = line_px[cur_width - 1 - col_pos];
        else if ($urandom_range(0, 1))
          p = $urandom_range(0, 1) ? level_a : level_b;
      end
      STYLE_COLUMN_RUN: begin
        if (row_pos > 0 && $urandom_range(0, 4) != 0) p = line_px[col_pos];
      end
      STYLE_FLAT: if ($urandom_range(0, 15) != 0) p = level_a;
      default: ;
    endcase
    return p;
  endfunction

  // Transfer one pixel, pausing between bursts when pacing is on
  task automatic stream_pixel(input logic [rfs_pkg::PIX_W-1:0] p);
    int gap;
    if (bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        pixel <= rfs_pkg::PIX_W'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_stats.push_back(predict_stats(p));
    pixels_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  // Hold the sender until every expected result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register on an idle block and mirror it in the predictor
  task automatic write_register(input logic [rfs_pkg::CFG_IDX_W-1:0] idx,
                                input logic [rfs_pkg::CFG_DATA_W-1:0] data);
    int v;
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    config_writes++;
    case (idx)
      rfs_pkg::CFG_IMAGE_WIDTH: begin
        v = int'(data);
        if (v < 2) v = 2;
        if (v > rfs_pkg::MAX_WIDTH) v = rfs_pkg::MAX_WIDTH;
        cur_width = v;
        col_pos = 0;
        row_pos = 0;
      end
      rfs_pkg::CFG_IMAGE_HEIGHT: begin
        v = int'(data[rfs_pkg::CFG_HGT_W-1:0]);
        if (v < 1) v = 1;
        if (v > rfs_pkg::MAX_HEIGHT) v = rfs_pkg::MAX_HEIGHT;
        cur_height = v;
        col_pos = 0;
        row_pos = 0;
      end
      rfs_pkg::CFG_CONTRAST_THRESHOLD: cur_threshold = int'(data[rfs_pkg::THR_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic send_list(input logic [rfs_pkg::PIX_W-1:0] list [$]);
    foreach (list[i]) stream_pixel(list[i]);
  endtask

  // Reset configuration: contrast below, at and well above the default threshold
  task automatic test_reset_defaults();
    send_list('{8'd0, 8'd255, 8'd127, 8'd0, 8'd200});
  endtask

  // Saturation, masking, ignored index and the frame restart on a size write
  task automatic test_register_limits();
    write_register(CFG_UNUSED, 10'h3FF);
    send_list('{8'd255, 8'd0});
    write_register(rfs_pkg::CFG_IMAGE_WIDTH, 10'd0);
    write_register(rfs_pkg::CFG_IMAGE_HEIGHT, 10'd0);
    write_register(rfs_pkg::CFG_CONTRAST_THRESHOLD, 10'h300);
    send_list('{8'd9, 8'd9, 8'd9, 8'd10});
    write_register(rfs_pkg::CFG_IMAGE_WIDTH, 10'h3FF);
    write_register(rfs_pkg::CFG_IMAGE_HEIGHT, 10'h3FF);
    write_register(rfs_pkg::CFG_CONTRAST_THRESHOLD, 10'h2FF);
    send_list('{8'd0, 8'd255, 8'd0});
  endtask

  // 3x3 frame: symmetric and asymmetric rows, full-swing contrast, column run
  task automatic test_small_frame();
    write_register(rfs_pkg::CFG_IMAGE_WIDTH, 10'd3);
    write_register(rfs_pkg::CFG_IMAGE_HEIGHT, 10'd3);
    write_register(rfs_pkg::CFG_CONTRAST_THRESHOLD, 10'd254);
    send_list('{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0});
  endtask

  // Widest single row, then the tallest two-column frame with long runs
  task automatic test_extreme_sizes();
    bursty = 1'b1;
    write_register(rfs_pkg::CFG_IMAGE_WIDTH, 10'd513);
    write_register(rfs_pkg::CFG_IMAGE_HEIGHT, 10'd1);
    write_register(rfs_pkg::CFG_CONTRAST_THRESHOLD, 10'd20);
    style = STYLE_MIRROR;
    level_a = rfs_pkg::PIX_W'($urandom);
    level_b = rfs_pkg::PIX_W'($urandom);
    repeat (cur_width * cur_height) stream_pixel(pick_pixel());
    write_register(rfs_pkg::CFG_IMAGE_WIDTH, 10'd2);
    write_register(rfs_pkg::CFG_IMAGE_HEIGHT, 10'd256);
    style = STYLE_FLAT;
    repeat (cur_width * cur_height) stream_pixel(pick_pixel());
  endtask

  // Random sizes, thresholds and pixel styles, with whole and partial frames
  task automatic test_random_frames();
    int                             goal;
    int                             count;
    int                             pick;
    logic [rfs_pkg::CFG_DATA_W-1:0] w_data;
    logic [rfs_pkg::CFG_DATA_W-1:0] h_data;
    logic [rfs_pkg::CFG_DATA_W-1:0] t_data;
    goal = pixels_sent + RANDOM_ITEMS;
    while (pixels_sent < goal) begin
      t_data = rfs_pkg::CFG_DATA_W'($urandom);
      pick = $urandom_range(0, 7);
      if (pick == 0) t_data = '0;
      else if (pick == 1) t_data[rfs_pkg::THR_W-1:0] = '1;
      else if (pick < 5) t_data = rfs_pkg::CFG_DATA_W'($urandom_range(0, 40));

      if ($urandom_range(0, 9) < 2) begin
        // threshold only: the frame in progress carries on
        write_register(rfs_pkg::CFG_CONTRAST_THRESHOLD, t_data);
        count = $urandom_range(1, 60);
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) w_data = rfs_pkg::CFG_DATA_W'($urandom_range(0, 1));
        else if (pick < 15) w_data = rfs_pkg::CFG_DATA_W'($urandom_range(2, 8));
        else w_data = rfs_pkg::CFG_DATA_W'($urandom_range(9, 40));
        pick = $urandom_range(0, 19);
        if (pick == 0) h_data = '0;
        else if (pick < 15) h_data = rfs_pkg::CFG_DATA_W'($urandom_range(1, 6));
        else h_data = rfs_pkg::CFG_DATA_W'($urandom_range(7, 12));
        h_data[rfs_pkg::CFG_DATA_W-1] = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) begin
          write_register(rfs_pkg::CFG_IMAGE_WIDTH, w_data);
          write_register(rfs_pkg::CFG_IMAGE_HEIGHT, h_data);
        end else begin
          write_register(rfs_pkg::CFG_IMAGE_HEIGHT, h_data);
          write_register(rfs_pkg::CFG_IMAGE_WIDTH, w_data);
        end
        write_register(rfs_pkg::CFG_CONTRAST_THRESHOLD, t_data);
        if ($urandom_range(0, 7) == 0)
          write_register(CFG_UNUSED, rfs_pkg::CFG_DATA_W'($urandom));
        count = cur_width * cur_height * ((cur_width > 8) ? 1 : $urandom_range(1, 3));
        if ($urandom_range(0, 3) == 0)
          count += $urandom_range(1, (cur_width * cur_height > 1) ?
                                     cur_width * cur_height - 1 : 1);
      end
      // keep the run near its item budget
      if (count > goal - pixels_sent) count = goal - pixels_sent;
      style = pixel_style_t'($urandom_range(0, 4));
      level_a = rfs_pkg::PIX_W'($urandom);
      level_b = rfs_pkg::PIX_W'($urandom);
      bursty = ($urandom_range(0, 3) != 0);
      repeat (count) stream_pixel(pick_pixel());
    end
  endtask

  // Receiver stall pattern: switch between randomly chosen stall styles
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 97 == 0) stall_style <= stall_style_t'($urandom_range(0, 3));
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_cycle % 3 == 0);
    endcase
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
      end else begin
        want_stats = expected_stats.pop_front();
        check_field("max_level", longint'(max_level), longint'(want_stats.max_level));
        check_field("min_level", longint'(min_level), longint'(want_stats.min_level));
        check_field("asymmetric_rows", longint'(asymmetric_rows),
                    longint'(want_stats.asymmetric_rows));
        check_field("contrast_pixels", longint'(contrast_pixels),
                    longint'(want_stats.contrast_pixels));
        check_field("longest_run", longint'(longest_run),
                    longint'(want_stats.longest_run));
        check_field("frame_done", longint'(frame_done), longint'(want_stats.frame_done));
        results_checked++;
        if (want_stats.frame_done) frames_seen++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_limits();
    test_small_frame();
    test_extreme_sizes();
    test_random_frames();
    drain_results();
    $display("Streamed %0d pixels over %0d register writes, %0d frames completed.",
             pixels_sent, config_writes, frames_seen);
    $display("Checked %0d results, %0d mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", expected_stats.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
